>>> hdl/rrop_pkg.sv
// Shared types and constants for the rounded-rectangle outline point generator.
// No dependencies; used by every module under hdl/.
`default_nettype none
package rrop_pkg;

  // CORDIC datapath: x and y are signed, Q1.30 with guard bits; z is a signed phase, 2^32 per turn
  localparam int XW = 34;
  // quotient bits of the phase divider (phase = j * 2^30 / ppc)
  localparam int QW = 30;
  localparam int ATAN_LEN = 24;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

  // configuration register indexes
  localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_CORNER_RATIO  = 3'd2;
  localparam logic [2:0] REG_CORNER_FACTOR = 3'd3;
  localparam logic [2:0] REG_MIN_POINTS    = 3'd4;

  // per-item side data that rides along the cell chains
  typedef struct packed {
    logic        vld;     // index below point count
    logic [1:0]  corner;  // 0 top-left .. 3 bottom-left, clockwise
    logic [15:0] radius;  // Q16.0, same units as the frame size
    logic [10:0] count;   // point count, 11-bit field
  } meta_t;

  // arctangent of 2^-i as a phase, 2^32 per turn
  function automatic logic [31:0] atan_phase(input int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

>>> hdl/rrop_div_cell.sv
// One restoring-division cell: produces one phase quotient bit per stage.
// Depends on rrop_pkg.
`default_nettype none
module rrop_div_cell import rrop_pkg::*; #(
  parameter int PW = 9
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  wire logic [PW-1:0] up_rem,
  input  wire logic [QW-1:0] up_quo,
  input  wire logic [PW-1:0] up_ppc,
  input  wire meta_t         up_meta,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output logic [PW-1:0]      dn_rem,
  output logic [QW-1:0]      dn_quo,
  output logic [PW-1:0]      dn_ppc,
  output meta_t              dn_meta
);

  logic          v_r;
  logic [PW-1:0] rem_r, ppc_r;
  logic [QW-1:0] quo_r;
  meta_t         meta_r;
  logic [PW:0]   rem2;
  logic          ge;
  logic [PW-1:0] rem_nxt;

  // shift remainder, trial subtract
  always_comb begin
    rem2    = {up_rem, 1'b0};
    ge      = rem2 >= {1'b0, up_ppc};
    rem_nxt = ge ? PW'(rem2 - {1'b0, up_ppc}) : PW'(rem2);
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      rem_r  <= rem_nxt;
      quo_r  <= {up_quo[QW-2:0], ge};
      ppc_r  <= up_ppc;
      meta_r <= up_meta;
    end
  end

  assign dn_valid = v_r;
  assign dn_rem   = rem_r;
  assign dn_quo   = quo_r;
  assign dn_ppc   = ppc_r;
  assign dn_meta  = meta_r;

endmodule
`default_nettype wire

>>> hdl/rrop_cordic_cell.sv
// One CORDIC rotation cell, iteration IDX, registered output.
// Depends on rrop_pkg.
`default_nettype none
module rrop_cordic_cell import rrop_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 up_valid,
  output logic                      up_ready,
  input  wire logic signed [XW-1:0] up_x,
  input  wire logic signed [XW-1:0] up_y,
  input  wire logic signed [XW-1:0] up_z,
  input  wire meta_t                up_meta,
  output logic                      dn_valid,
  input  wire logic                 dn_ready,
  output logic signed [XW-1:0]      dn_x,
  output logic signed [XW-1:0]      dn_y,
  output logic signed [XW-1:0]      dn_z,
  output meta_t                     dn_meta
);

  localparam logic signed [XW-1:0] ATAN = XW'(atan_phase(IDX));

  logic                 v_r;
  logic signed [XW-1:0] x_r, y_r, z_r;
  meta_t                meta_r;
  logic signed [XW-1:0] dx, dy, x_nxt, y_nxt, z_nxt;

  // rotate toward z = 0
  always_comb begin
    dx = up_y >>> IDX;
    dy = up_x >>> IDX;
    if (!up_z[XW-1]) begin
      x_nxt = up_x - dx;
      y_nxt = up_y + dy;
      z_nxt = up_z - ATAN;
    end else begin
      x_nxt = up_x + dx;
      y_nxt = up_y - dy;
      z_nxt = up_z + ATAN;
    end
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      meta_r <= up_meta;
    end
  end

  assign dn_valid = v_r;
  assign dn_x     = x_r;
  assign dn_y     = y_r;
  assign dn_z     = z_r;
  assign dn_meta  = meta_r;

endmodule
`default_nettype wire

>>> hdl/rounded_rect_outline_points.sv
// Path from input transaction to result, in order:
//   four setup stages, 30 phase-divider cells, the CORDIC cells, a multiply and an output stage.
// Throughput: one transaction per cycle; every stage holds its item only while the next is full.
// Reset (rst_n low, synchronous) empties all stages and loads the register defaults.
// Depends on rrop_pkg, rrop_div_cell and rrop_cordic_cell.
`default_nettype none
module rounded_rect_outline_points import rrop_pkg::*; #(
  parameter int MAX_POINTS_PER_CORNER = 256,
  parameter int CORDIC_ITERATIONS     = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [9:0]  in_point_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_point_x,
  output logic [15:0]      out_point_y,
  output logic [10:0]      out_point_count,
  output logic             out_index_valid,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int PW  = $clog2(MAX_POINTS_PER_CORNER + 1);
  localparam int NC  = CORDIC_ITERATIONS;
  localparam int PRW = XW + 17;
  localparam logic [15:0] MAX16 = 16'(MAX_POINTS_PER_CORNER);
  localparam logic signed [PRW-1:0] HALF = PRW'(64'sd536870912);

  // configuration registers
  logic [15:0] frame_width_r, frame_height_r, corner_ratio_r;
  logic [11:0] corner_factor_r;
  logic [8:0]  min_points_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= 16'd0;
      frame_height_r  <= 16'd0;
      corner_ratio_r  <= 16'd6554;
      corner_factor_r <= 12'd768;
      min_points_r    <= 9'd8;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:   frame_width_r   <= cfg_data;
        REG_FRAME_HEIGHT:  frame_height_r  <= cfg_data;
        REG_CORNER_RATIO:  corner_ratio_r  <= cfg_data;
        REG_CORNER_FACTOR: corner_factor_r <= cfg_data[11:0];
        REG_MIN_POINTS:    min_points_r    <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // stage 1: smaller side times ratio
  logic        v1_r, rdy1;
  logic [9:0]  idx1_r;
  logic [31:0] sprod1_r;
  logic [15:0] side;
  logic        rdy2;

  assign side     = (frame_width_r < frame_height_r) ? frame_width_r : frame_height_r;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      idx1_r   <= in_point_index;
      sprod1_r <= side * corner_ratio_r;
    end
  end

  // stage 2: radius times corner factor
  logic        v2_r, rdy3;
  logic [9:0]  idx2_r;
  logic [15:0] rad2_r;
  logic [27:0] fprod2_r;

  assign rdy2 = !v2_r || rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r && rdy2) begin
      idx2_r   <= idx1_r;
      rad2_r   <= sprod1_r[31:16];
      fprod2_r <= sprod1_r[31:16] * corner_factor_r;
    end
  end

  // stage 3: points per corner, bounded below and saturated
  logic          v3_r, rdy4;
  logic [9:0]    idx3_r;
  logic [15:0]   rad3_r;
  logic [PW-1:0] ppc3_r;
  logic [15:0]   raw, mn16, pmax, psat;

  always_comb begin
    raw  = fprod2_r[27:12];
    mn16 = (min_points_r == 9'd0) ? 16'd1 : {7'd0, min_points_r};
    pmax = (raw > mn16) ? raw : mn16;
    psat = (pmax > MAX16) ? MAX16 : pmax;
  end

  assign rdy3 = !v3_r || rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r && rdy3) begin
      idx3_r <= idx2_r;
      rad3_r <= rad2_r;
      ppc3_r <= PW'(psat);
    end
  end

  // stage 4: corner number, offset within the corner, range check
  logic          v4_r;
  logic [PW-1:0] rem4_r, ppc4_r;
  meta_t         meta4_r;
  logic [12:0]   idx13, p13, p2, p3, cnt13, sel;
  logic          c1, c2, c3, vld;
  logic [1:0]    corner;
  logic [PW-1:0] jv;

  always_comb begin
    idx13 = 13'(idx3_r);
    p13   = 13'(ppc3_r);
    p2    = p13 << 1;
    p3    = p13 + p2;
    cnt13 = p13 << 2;
    vld   = idx13 < cnt13;
    c1    = idx13 >= p13;
    c2    = idx13 >= p2;
    c3    = idx13 >= p3;
    if (!vld) begin
      corner = 2'd0;
      sel    = idx13;
    end else if (c3) begin
      corner = 2'd3;
      sel    = p3;
    end else if (c2) begin
      corner = 2'd2;
      sel    = p2;
    end else if (c1) begin
      corner = 2'd1;
      sel    = p13;
    end else begin
      corner = 2'd0;
      sel    = 13'd0;
    end
    jv = PW'(idx13 - sel);
  end

  logic            dv  [0:QW];
  logic            drdy[0:QW];
  logic [PW-1:0]   drem[0:QW];
  logic [QW-1:0]   dquo[0:QW];
  logic [PW-1:0]   dppc[0:QW];
  meta_t           dmeta[0:QW];

  assign rdy4 = !v4_r || drdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r && rdy4) begin
      rem4_r         <= jv;
      ppc4_r         <= ppc3_r;
      meta4_r.vld    <= vld;
      meta4_r.corner <= corner;
      meta4_r.radius <= rad3_r;
      meta4_r.count  <= 11'(cnt13);
    end
  end

  // phase divider: one quotient bit per cell
  assign dv[0]    = v4_r;
  assign drem[0]  = rem4_r;
  assign dquo[0]  = '0;
  assign dppc[0]  = ppc4_r;
  assign dmeta[0] = meta4_r;

  for (genvar i = 0; i < QW; i++) begin : g_div
    rrop_div_cell #(.PW(PW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv[i]),
      .up_ready (drdy[i]),
      .up_rem   (drem[i]),
      .up_quo   (dquo[i]),
      .up_ppc   (dppc[i]),
      .up_meta  (dmeta[i]),
      .dn_valid (dv[i+1]),
      .dn_ready (drdy[i+1]),
      .dn_rem   (drem[i+1]),
      .dn_quo   (dquo[i+1]),
      .dn_ppc   (dppc[i+1]),
      .dn_meta  (dmeta[i+1])
    );
  end

  // CORDIC rotation cells
  logic                 cv  [0:NC];
  logic                 crdy[0:NC];
  logic signed [XW-1:0] cx  [0:NC];
  logic signed [XW-1:0] cy  [0:NC];
  logic signed [XW-1:0] cz  [0:NC];
  meta_t                cmeta[0:NC];

  assign cv[0]      = dv[QW];
  assign drdy[QW]   = crdy[0];
  assign cx[0]      = CORDIC_GAIN;
  assign cy[0]      = '0;
  assign cz[0]      = XW'(dquo[QW]);
  assign cmeta[0]   = dmeta[QW];

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    rrop_cordic_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cv[i]),
      .up_ready (crdy[i]),
      .up_x     (cx[i]),
      .up_y     (cy[i]),
      .up_z     (cz[i]),
      .up_meta  (cmeta[i]),
      .dn_valid (cv[i+1]),
      .dn_ready (crdy[i+1]),
      .dn_x     (cx[i+1]),
      .dn_y     (cy[i+1]),
      .dn_z     (cz[i+1]),
      .dn_meta  (cmeta[i+1])
    );
  end

  // multiply stage: rotate cos/sin to the corner's quadrant, scale by radius
  logic                  vm_r, rdym, rdyo;
  logic signed [PRW-1:0] prx_r, pry_r;
  meta_t                 metam_r;
  logic signed [XW-1:0]  ca, sa, cc, ss;
  logic signed [16:0]    rads;

  always_comb begin
    cc   = cx[NC];
    ss   = cy[NC];
    rads = $signed({1'b0, cmeta[NC].radius});
    case (cmeta[NC].corner)
      2'd0: begin
        ca = -cc;
        sa = -ss;
      end
      2'd1: begin
        ca = ss;
        sa = -cc;
      end
      2'd2: begin
        ca = cc;
        sa = ss;
      end
      default: begin
        ca = -ss;
        sa = cc;
      end
    endcase
  end

  assign rdym         = !vm_r || rdyo;
  assign crdy[NC]     = rdym;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (rdym) begin
      vm_r <= cv[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (cv[NC] && rdym) begin
      prx_r   <= ca * rads;
      pry_r   <= sa * rads;
      metam_r <= cmeta[NC];
    end
  end

  // output stage: round, add corner center, clamp
  logic                  vo_r;
  logic [15:0]           px_r, py_r;
  logic [10:0]           cnt_r;
  logic                  iv_r;
  logic [15:0]           ctrx, ctry, px_nxt, py_nxt;
  logic signed [PRW-1:0] offx, offy, vx, vy;

  always_comb begin
    ctrx = (metam_r.corner == 2'd1 || metam_r.corner == 2'd2)
           ? frame_width_r - metam_r.radius : metam_r.radius;
    ctry = (metam_r.corner == 2'd2 || metam_r.corner == 2'd3)
           ? frame_height_r - metam_r.radius : metam_r.radius;
    offx = (prx_r + HALF) >>> 30;
    offy = (pry_r + HALF) >>> 30;
    vx   = offx + $signed(PRW'(ctrx));
    vy   = offy + $signed(PRW'(ctry));
    if (!metam_r.vld || vx[PRW-1]) begin
      px_nxt = 16'd0;
    end else if (vx > $signed(PRW'(16'hFFFF))) begin
      px_nxt = 16'hFFFF;
    end else begin
      px_nxt = vx[15:0];
    end
    if (!metam_r.vld || vy[PRW-1]) begin
      py_nxt = 16'd0;
    end else if (vy > $signed(PRW'(16'hFFFF))) begin
      py_nxt = 16'hFFFF;
    end else begin
      py_nxt = vy[15:0];
    end
  end

  assign rdyo = !vo_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (rdyo) begin
      vo_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (vm_r && rdyo) begin
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      cnt_r <= metam_r.count;
      iv_r  <= metam_r.vld;
    end
  end

  assign out_valid       = vo_r;
  assign out_point_x     = px_r;
  assign out_point_y     = py_r;
  assign out_point_count = cnt_r;
  assign out_index_valid = iv_r;

  // checks
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_index_valid |-> out_point_x == 16'd0 && out_point_y == 16'd0)
    else $error("out-of-range index gave nonzero point");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r)
    else $error("input stalled with empty first stage");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && meta4_r.vld |-> rem4_r < ppc4_r)
    else $error("corner offset not below points per corner");

  a_mult_held: assert property (@(posedge clk) disable iff (!rst_n)
    vm_r && !rdyo |=> vm_r && $stable(prx_r) && $stable(pry_r))
    else $error("multiply stage lost a held item");

endmodule
`default_nettype wire

>>> tb/tb.sv
// Testbench for rounded_rect_outline_points: random and directed vertex queries under
// several idling phases, checked against an in-bench fixed-point outline predictor.
// Depends on rrop_pkg and the RTL under hdl/.
`default_nettype none
module tb import rrop_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [10:0] count;
    logic        ivalid;
  } vertex_t;

  // expected-vertex store and checker
  class outline_scoreboard;
    vertex_t pending[$];
    int      mismatches;

    // register copies
    logic [15:0] width, height, ratio;
    logic [11:0] factor;
    logic [8:0]  min_ppc;
    int          iters;

    function void reset_regs();
      width = 16'd0; height = 16'd0; ratio = 16'd6554; factor = 12'd768; min_ppc = 9'd8;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_FRAME_WIDTH:   width = data;
        REG_FRAME_HEIGHT:  height = data;
        REG_CORNER_RATIO:  ratio = data;
        REG_CORNER_FACTOR: factor = data[11:0];
        REG_MIN_POINTS:    min_ppc = data[8:0];
        default: ;
      endcase
    endfunction

    // floor shift for signed values
    function longint fshr(longint v, int s);
      return v >>> s;
    endfunction

    function longint offset_of(longint trig, longint radius);
      return fshr(trig * radius + (64'sd1 <<< 29), 30);
    endfunction

    function logic [15:0] clamp(longint v);
      if (v < 0) return 16'd0;
      if (v > 65535) return 16'hFFFF;
      return v[15:0];
    endfunction

    function void note_query(logic [9:0] idx);
      vertex_t e;
      longint side, radius, raw, ppc, cnt, j, ph, cx, cy, c, s, ca, sa, z, dx, dy;
      int corner;
      side = (width < height) ? width : height;
      radius = (side * ratio) >>> 16;
      raw = (radius * factor) >>> 12;
      ppc = (min_ppc == 0) ? 1 : min_ppc;
      if (raw > ppc) ppc = raw;
      if (ppc > 256) ppc = 256;
      cnt = 4 * ppc;
      e.count = cnt[10:0];
      e.ivalid = (idx < cnt);
      e.x = 16'd0; e.y = 16'd0;
      if (e.ivalid) begin
        corner = int'(idx / ppc);
        j = idx % ppc;
        ph = (j * 64'h40000000) / ppc;
        c = 652032874; s = 0; z = ph;
        for (int i = 0; i < iters; i++) begin
          dx = fshr(s, i);
          dy = fshr(c, i);
          if (z >= 0) begin
            c -= dx; s += dy; z -= atan_phase(i);
          end else begin
            c += dx; s -= dy; z += atan_phase(i);
          end
        end
        case (corner & 3)
          0: begin cx = radius; cy = radius; ca = -c; sa = -s; end
          1: begin cx = (width - radius) & 32'hFFFFFFFF; cy = radius; ca = s; sa = -c; end
          2: begin
            cx = (width - radius) & 32'hFFFFFFFF; cy = (height - radius) & 32'hFFFFFFFF;
            ca = c; sa = s;
          end
          default: begin cx = radius; cy = (height - radius) & 32'hFFFFFFFF; ca = -s; sa = c; end
        endcase
        e.x = clamp(cx + offset_of(ca, radius));
        e.y = clamp(cy + offset_of(sa, radius));
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic [15:0] x, logic [15:0] y, logic [10:0] cnt, logic iv);
      vertex_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%0d y=%0d", x, y);
        return;
      end
      e = pending.pop_front();
      if (x !== e.x || y !== e.y || cnt !== e.count || iv !== e.ivalid) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp x=%0d y=%0d n=%0d v=%0d got x=%0d y=%0d n=%0d v=%0d",
                   e.x, e.y, e.count, e.ivalid, x, y, cnt, iv);
      end
    endfunction
  endclass

  localparam int ITERS = 16;
  localparam int LATENCY = 36 + ITERS;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall;
  logic [9:0] in_point_index = 0;
  logic out_valid, out_stall = 0;
  logic [15:0] out_point_x, out_point_y;
  logic [10:0] out_point_count;
  logic out_index_valid;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;

  int send_idle_pct = 0, stall_pct = 0;
  outline_scoreboard sb;

  rounded_rect_outline_points dut (.*);

  initial forever #1 clk = ~clk;

  initial begin
    #2000000;
    $display("FAIL rounded_rect_outline_points");
    $finish;
  end

  // result side: random stall, check at rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_point_x, out_point_y, out_point_count, out_index_valid);
  end
  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // one query transaction; valid stays high across back-to-back items
  task automatic send_query(logic [9:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; in_point_index <= idx;
    do @(posedge clk); while (in_stall);
    sb.note_query(idx);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_shape(int w, int h, int r, int f, int m);
    write_reg(REG_FRAME_WIDTH, 16'(w));
    write_reg(REG_FRAME_HEIGHT, 16'(h));
    write_reg(REG_CORNER_RATIO, 16'(r));
    write_reg(REG_CORNER_FACTOR, 16'(f));
    write_reg(REG_MIN_POINTS, 16'(m));
  endtask

  // index mostly within the current outline
  function automatic logic [9:0] pick_index(int cnt);
    if ($urandom_range(9) == 0) return 10'($urandom_range(1023));
    return 10'($urandom_range(cnt > 1024 ? 1023 : cnt - 1));
  endfunction

  initial begin
    int cnt;
    sb = new();
    sb.iters = ITERS;
    sb.reset_regs();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // defaults: zero size, then a few directed shapes
    send_query(0); send_query(31); send_query(32); send_query(1023);
    drain();
    set_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 0);
    send_query(0); send_query(255); send_query(256); send_query(511);
    send_query(767); send_query(1023); send_query(10'h2AA); send_query(10'h155);
    drain();
    set_shape(16'd1600, 16'd800, 16'd16384, 12'd256, 9'd256);
    send_query(0); send_query(1023); send_query(300);
    drain();
    set_shape(16'd0, 16'd500, 16'd32768, 12'd0, 9'd1);
    send_query(0); send_query(1); send_query(3); send_query(4);
    drain();
    write_reg(3'd5, 16'hFFFF);
    write_reg(3'd7, 16'h1234);
    send_query(2); send_query(7);
    drain();

    // random phases over several idling mixes
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      set_shape($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                $urandom_range(4095), $urandom_range(ph == 3 ? 511 : 40));
      cnt = sb.pending.size();
      begin
        vertex_t dummy;
        sb.note_query(0);
        dummy = sb.pending.pop_back();
        cnt = dummy.count == 0 ? 1024 : dummy.count;
      end
      for (int k = 0; k < 100; k++) send_query(pick_index(cnt));
      drain();
    end

    if (sb.mismatches == 0)
      $display("PASS rounded_rect_outline_points");
    else
      $display("FAIL rounded_rect_outline_points");
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
hdl/rrop_pkg.sv
hdl/rrop_div_cell.sv
hdl/rrop_cordic_cell.sv
hdl/rounded_rect_outline_points.sv
tb/tb.sv
